[rtl/assert_macros.svh]
// assertion helpers, clocked on i_clk and quiet while i_rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds in the same cycle
`define ASSERT_NOW(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("assertion failed");

// antecedent in one cycle implies consequent in the next
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[rtl/acs_pkg.sv]
`default_nettype none

package acs_pkg;

    localparam int COUNT_BITS_DEF = 16;
    localparam int CFG_DATA_W     = 16;
    localparam int CFG_IDX_W      = 2;
    localparam int RESET_TICKS    = 100;
    localparam int RESET_TICKS_W  = 7;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PRESS_OVERRIDE = 2'd0,
        CFG_SETTLE_TICKS   = 2'd1,
        CFG_RAISE_TICKS    = 2'd2,
        CFG_VACUUM_TICKS   = 2'd3
    } t_cfg_idx;

    typedef enum logic [3:0] {
        MODE_STOPPED   = 4'd0,
        MODE_ERROR     = 4'd1,
        MODE_UP        = 4'd2,
        MODE_DOWN      = 4'd3,
        MODE_SENSED    = 4'd4,
        MODE_TUNE_UP   = 4'd5,
        MODE_TUNE_DOWN = 4'd6,
        MODE_AT_BOARD  = 4'd7,
        MODE_RAISE     = 4'd8,
        MODE_VACUUM    = 4'd9,
        MODE_IN_POS    = 4'd10
    } t_mode;

    typedef enum logic [2:0] {
        MOTOR_HALT      = 3'd0,
        MOTOR_UP_FAST   = 3'd1,
        MOTOR_UP_SLOW   = 3'd2,
        MOTOR_DOWN_SLOW = 3'd3,
        MOTOR_DOWN_FAST = 3'd4
    } t_motor;

    localparam logic [1:0] TOUCH_LOW  = 2'd0;
    localparam logic [1:0] TOUCH_MID  = 2'd1;
    localparam logic [1:0] TOUCH_HIGH = 2'd2;

    typedef struct packed {
        logic       start_press;
        logic [1:0] touch_level;
        logic       cup_released;
        logic       cup_lowered;
        logic       vacuum_valve_off;
        logic       has_vacuum;
        logic       drive_fault;
    } t_in_word;

    typedef struct packed {
        logic [3:0] mode;
        logic [2:0] motor_cmd;
        logic       cup_on;
        logic       vacuum_on;
    } t_out_word;

endpackage

`default_nettype wire

[rtl/acs_stream_if.sv]
`default_nettype none

interface acs_stream_if #(
    parameter type t_word = logic
) ();
    logic  valid;
    logic  ready;
    t_word word;

    modport source (output valid, output word, input ready);
    modport sink (input valid, input word, output ready);
endinterface

`default_nettype wire

[rtl/acs_cfg.sv]
`default_nettype none

module acs_cfg #(
    parameter int COUNT_BITS = acs_pkg::COUNT_BITS_DEF,
    localparam int THR_W = (COUNT_BITS > acs_pkg::RESET_TICKS_W) ?
                           COUNT_BITS : acs_pkg::RESET_TICKS_W
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_wen,
    input  wire logic [acs_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [acs_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                                o_press_override,
    output logic [THR_W-1:0]                    o_settle_ticks,
    output logic [THR_W-1:0]                    o_raise_ticks,
    output logic [THR_W-1:0]                    o_vacuum_ticks
);

    logic             r_press_override;
    logic [THR_W-1:0] r_settle_ticks;
    logic [THR_W-1:0] r_raise_ticks;
    logic [THR_W-1:0] r_vacuum_ticks;
    logic [THR_W-1:0] wr_thr;

    // thresholds keep COUNT_BITS bits of the written data
    assign wr_thr = THR_W'(COUNT_BITS'(i_cfg_data));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_press_override <= 1'b0;
            r_settle_ticks   <= THR_W'(acs_pkg::RESET_TICKS);
            r_raise_ticks    <= THR_W'(acs_pkg::RESET_TICKS);
            r_vacuum_ticks   <= THR_W'(acs_pkg::RESET_TICKS);
        end else if (i_cfg_wen) begin
            unique case (acs_pkg::t_cfg_idx'(i_cfg_idx))
                acs_pkg::CFG_PRESS_OVERRIDE: r_press_override <= i_cfg_data[0];
                acs_pkg::CFG_SETTLE_TICKS:   r_settle_ticks   <= wr_thr;
                acs_pkg::CFG_RAISE_TICKS:    r_raise_ticks    <= wr_thr;
                acs_pkg::CFG_VACUUM_TICKS:   r_vacuum_ticks   <= wr_thr;
            endcase
        end
    end

    assign o_press_override = r_press_override;
    assign o_settle_ticks   = r_settle_ticks;
    assign o_raise_ticks    = r_raise_ticks;
    assign o_vacuum_ticks   = r_vacuum_ticks;

endmodule

`default_nettype wire

[rtl/acs_core.sv]
`default_nettype none

module acs_core #(
    parameter int COUNT_BITS = acs_pkg::COUNT_BITS_DEF,
    localparam int THR_W = (COUNT_BITS > acs_pkg::RESET_TICKS_W) ?
                           COUNT_BITS : acs_pkg::RESET_TICKS_W
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_step,
    input  wire acs_pkg::t_in_word  i_word,
    input  wire logic               i_press_override,
    input  wire logic [THR_W-1:0]   i_settle_ticks,
    input  wire logic [THR_W-1:0]   i_raise_ticks,
    input  wire logic [THR_W-1:0]   i_vacuum_ticks,
    output acs_pkg::t_out_word      o_result
);

    localparam int CNT_W = COUNT_BITS + 1;
    localparam int CMP_W = (THR_W > CNT_W) ? THR_W : CNT_W;

    acs_pkg::t_mode  r_mode, n_mode;
    acs_pkg::t_motor r_motor, n_motor;
    logic            r_cup, n_cup;
    logic            r_vac, n_vac;
    logic [CNT_W-1:0] r_dwell, n_dwell;

    logic             forced;
    logic             start_ok;
    logic             timed;
    logic [THR_W-1:0] sel_thr;
    logic             dwell_done;

    assign forced   = i_word.start_press & i_press_override;
    assign start_ok = i_word.start_press & i_word.cup_released & i_word.cup_lowered &
                      i_word.vacuum_valve_off & ~i_word.has_vacuum &
                      (i_word.touch_level == acs_pkg::TOUCH_LOW) & ~i_word.drive_fault;

    always_comb begin
        timed   = 1'b1;
        sel_thr = i_settle_ticks;
        unique case (r_mode)
            acs_pkg::MODE_AT_BOARD: sel_thr = i_settle_ticks;
            acs_pkg::MODE_RAISE:    sel_thr = i_raise_ticks;
            acs_pkg::MODE_VACUUM:   sel_thr = i_vacuum_ticks;
            default:                timed   = 1'b0;
        endcase
    end

    // a forced press leaves a timed mode without counting
    assign dwell_done = forced || (CMP_W'(r_dwell) >= CMP_W'(sel_thr));

    // next mode
    always_comb begin
        n_mode = r_mode;
        unique case (r_mode)
            acs_pkg::MODE_STOPPED: begin
                if (start_ok || forced) n_mode = acs_pkg::MODE_UP;
            end
            acs_pkg::MODE_UP: begin
                if (i_word.touch_level == acs_pkg::TOUCH_MID) begin
                    n_mode = acs_pkg::MODE_SENSED;
                end else if (i_word.touch_level == acs_pkg::TOUCH_HIGH) begin
                    n_mode = acs_pkg::MODE_TUNE_DOWN;
                end
            end
            acs_pkg::MODE_SENSED: begin
                if (i_word.touch_level == acs_pkg::TOUCH_HIGH) begin
                    n_mode = acs_pkg::MODE_TUNE_DOWN;
                end else if (i_word.touch_level == acs_pkg::TOUCH_MID || forced) begin
                    n_mode = acs_pkg::MODE_AT_BOARD;
                end
            end
            acs_pkg::MODE_TUNE_DOWN: begin
                if (i_word.touch_level == acs_pkg::TOUCH_MID) begin
                    n_mode = acs_pkg::MODE_AT_BOARD;
                end else if (i_word.touch_level == acs_pkg::TOUCH_LOW) begin
                    n_mode = acs_pkg::MODE_TUNE_UP;
                end
            end
            acs_pkg::MODE_TUNE_UP: begin
                if (i_word.touch_level == acs_pkg::TOUCH_MID) begin
                    n_mode = acs_pkg::MODE_AT_BOARD;
                end else if (i_word.touch_level == acs_pkg::TOUCH_HIGH) begin
                    n_mode = acs_pkg::MODE_TUNE_DOWN;
                end
            end
            acs_pkg::MODE_AT_BOARD: begin
                if (dwell_done) n_mode = acs_pkg::MODE_RAISE;
            end
            acs_pkg::MODE_RAISE: begin
                if (dwell_done) n_mode = acs_pkg::MODE_VACUUM;
            end
            acs_pkg::MODE_VACUUM: begin
                if (dwell_done) n_mode = acs_pkg::MODE_IN_POS;
            end
            acs_pkg::MODE_IN_POS: begin
                if (forced) n_mode = acs_pkg::MODE_DOWN;
            end
            acs_pkg::MODE_DOWN: begin
                if (forced) n_mode = acs_pkg::MODE_STOPPED;
            end
            default: n_mode = r_mode;
        endcase
    end

    // held commands and dwell count
    always_comb begin
        n_motor = r_motor;
        n_cup   = r_cup;
        n_vac   = r_vac;
        unique case (r_mode)
            acs_pkg::MODE_UP:        n_motor = acs_pkg::MOTOR_UP_FAST;
            acs_pkg::MODE_SENSED:    n_motor = acs_pkg::MOTOR_HALT;
            acs_pkg::MODE_TUNE_DOWN: n_motor = acs_pkg::MOTOR_DOWN_SLOW;
            acs_pkg::MODE_TUNE_UP:   n_motor = acs_pkg::MOTOR_UP_SLOW;
            acs_pkg::MODE_AT_BOARD:  n_motor = acs_pkg::MOTOR_HALT;
            acs_pkg::MODE_RAISE:     n_cup   = 1'b1;
            acs_pkg::MODE_VACUUM:    n_vac   = 1'b1;
            acs_pkg::MODE_IN_POS:    n_cup   = 1'b0;
            acs_pkg::MODE_DOWN: begin
                n_motor = acs_pkg::MOTOR_DOWN_FAST;
                n_vac   = 1'b0;
            end
            default: begin
                n_motor = acs_pkg::MOTOR_HALT;
                n_cup   = 1'b0;
                n_vac   = 1'b0;
            end
        endcase

        if (n_mode != r_mode) begin
            n_dwell = '0;
        end else if (timed && !dwell_done) begin
            n_dwell = r_dwell + CNT_W'(1);
        end else begin
            n_dwell = r_dwell;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= acs_pkg::MODE_STOPPED;
            r_motor <= acs_pkg::MOTOR_HALT;
            r_cup   <= 1'b0;
            r_vac   <= 1'b0;
            r_dwell <= '0;
        end else if (i_step) begin
            r_mode  <= n_mode;
            r_motor <= n_motor;
            r_cup   <= n_cup;
            r_vac   <= n_vac;
            r_dwell <= n_dwell;
        end
    end

    assign o_result.mode      = n_mode;
    assign o_result.motor_cmd = n_motor;
    assign o_result.cup_on    = n_cup;
    assign o_result.vacuum_on = n_vac;

endmodule

`default_nettype wire

[rtl/actuator_cycle_sequencer.sv]
// Actuator cycle sequencer: walks an actuator through one board cycle.
// Input channel i_in carries one control tick per word: start press, touch
// level and interlock status. Output channel o_out returns one word per tick
// with the mode after the tick and the held motor, cup and vacuum commands.
// Both channels move a word on a rising edge where valid and ready are high.
// Configuration: i_cfg_wen/i_cfg_idx/i_cfg_data write press override (0)
// and the settle, raise and vacuum dwell thresholds (1..3); the user is to
// write them only while idle; the block does not enforce it. A word taken
// is registered, and its result enters the output register when it advances.
// Throughput: one word per cycle while o_out.ready is high; the mode update
// is a single short step of next-state logic between the two registers.
// When the receiver stalls the output word holds, the input register fills,
// and i_in.ready drops until o_out.ready returns.
// Reset: mode stopped, dwell count zero, all commands off, press override
// off, thresholds 100, both pipeline registers empty.
`default_nettype none

module actuator_cycle_sequencer #(
    parameter int COUNT_BITS = acs_pkg::COUNT_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    acs_stream_if.sink                          i_in,
    acs_stream_if.source                        o_out,
    input  wire logic                           i_cfg_wen,
    input  wire logic [acs_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [acs_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int THR_W = (COUNT_BITS > acs_pkg::RESET_TICKS_W) ?
                           COUNT_BITS : acs_pkg::RESET_TICKS_W;

    logic               r_s1_valid;
    acs_pkg::t_in_word  r_s1_word;
    logic               r_out_valid;
    acs_pkg::t_out_word r_out_word;

    logic               adv;
    logic               in_ready;
    acs_pkg::t_out_word result;

    logic             press_override;
    logic [THR_W-1:0] settle_ticks;
    logic [THR_W-1:0] raise_ticks;
    logic [THR_W-1:0] vacuum_ticks;

    assign adv      = !r_out_valid || o_out.ready;
    assign in_ready = !r_s1_valid || adv;

    acs_cfg #(
        .COUNT_BITS(COUNT_BITS)
    ) u_cfg (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wen        (i_cfg_wen),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .o_press_override (press_override),
        .o_settle_ticks   (settle_ticks),
        .o_raise_ticks    (raise_ticks),
        .o_vacuum_ticks   (vacuum_ticks)
    );

    acs_core #(
        .COUNT_BITS(COUNT_BITS)
    ) u_core (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_step           (r_s1_valid && adv),
        .i_word           (r_s1_word),
        .i_press_override (press_override),
        .i_settle_ticks   (settle_ticks),
        .i_raise_ticks    (raise_ticks),
        .i_vacuum_ticks   (vacuum_ticks),
        .o_result         (result)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_ready) begin
            r_s1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_in.valid) begin
            r_s1_word <= i_in.word;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_s1_valid) begin
            r_out_word <= result;
        end
    end

    assign i_in.ready  = in_ready;
    assign o_out.valid = r_out_valid;
    assign o_out.word  = r_out_word;

endmodule

`default_nettype wire

[rtl/acs_chk.sv]
`default_nettype none
`include "assert_macros.svh"

module acs_chk (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_out_valid,
    input wire logic               i_out_ready,
    input wire acs_pkg::t_out_word i_out_word
);

    logic mode_legal;
    logic raise_motor_ok;
    logic vacuum_cup_ok;

    assign mode_legal     = (i_out_word.mode <= 4'(acs_pkg::MODE_IN_POS)) &&
                            (i_out_word.mode != 4'(acs_pkg::MODE_ERROR));
    assign raise_motor_ok = (i_out_word.mode != 4'(acs_pkg::MODE_RAISE)) ||
                            (i_out_word.motor_cmd == 3'(acs_pkg::MOTOR_HALT));
    assign vacuum_cup_ok  = (i_out_word.mode != 4'(acs_pkg::MODE_VACUUM)) ||
                            i_out_word.cup_on;

    // a stalled result word stays put
    `ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_word))

    // only reachable modes are reported
    `ASSERT_NOW(a_mode_range, !i_out_valid || mode_legal)

    // raise is entered only from at board, which stopped the motor
    `ASSERT_NOW(a_raise_motor, !i_out_valid || raise_motor_ok)

    // vacuum is entered only from raise, which switched the cup on
    `ASSERT_NOW(a_vacuum_cup, !i_out_valid || vacuum_cup_ok)

endmodule

bind actuator_cycle_sequencer acs_chk u_acs_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_word  (o_out.word)
);

`default_nettype wire

[verif/actuator_cycle_sequencer_tb.sv]
`timescale 1ns / 100ps

module actuator_cycle_sequencer_tb;
    import acs_pkg::*;

    localparam int COUNT_BITS = COUNT_BITS_DEF;
    localparam int IDLE_LIMIT = 2000;
    localparam logic [1:0] TOUCH_NONE = 2'd3;

    class sequencer_mirror;
        bit                  press_force_en;
        bit [COUNT_BITS-1:0] settle_thr;
        bit [COUNT_BITS-1:0] raise_thr;
        bit [COUNT_BITS-1:0] vacuum_thr;
        t_mode               mode;
        bit [COUNT_BITS:0]   dwell;
        t_motor              motor;
        bit                  cup_hold;
        bit                  vac_hold;
        t_out_word           expected_words[$];
        int                  mismatches;

        function new();
            press_force_en = 1'b0;
            settle_thr     = COUNT_BITS'(RESET_TICKS);
            raise_thr      = COUNT_BITS'(RESET_TICKS);
            vacuum_thr     = COUNT_BITS'(RESET_TICKS);
            mode           = MODE_STOPPED;
            dwell          = '0;
            mismatches     = 0;
            drop_commands();
        endfunction

        function void drop_commands();
            motor    = MOTOR_HALT;
            cup_hold = 1'b0;
            vac_hold = 1'b0;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_PRESS_OVERRIDE: press_force_en = data[0];
                CFG_SETTLE_TICKS:   settle_thr = COUNT_BITS'(data);
                CFG_RAISE_TICKS:    raise_thr = COUNT_BITS'(data);
                CFG_VACUUM_TICKS:   vacuum_thr = COUNT_BITS'(data);
                default: ;
            endcase
        endfunction

        // compare the old count, count up only while staying
        function bit dwell_done(bit forced, bit [COUNT_BITS-1:0] thr);
            if (forced) return 1'b1;
            if (dwell >= {1'b0, thr}) return 1'b1;
            dwell = dwell + 1'b1;
            return 1'b0;
        endfunction

        function void note_tick(t_in_word w);
            bit        forced;
            bit        start_ok;
            t_mode     next;
            t_out_word want;
            forced   = w.start_press && press_force_en;
            start_ok = w.start_press && w.cup_released && w.cup_lowered
                       && w.vacuum_valve_off && !w.has_vacuum
                       && w.touch_level == TOUCH_LOW && !w.drive_fault;
            next = mode;
            case (mode)
                MODE_STOPPED: begin
                    drop_commands();
                    if (start_ok || forced) next = MODE_UP;
                end
                MODE_UP: begin
                    motor = MOTOR_UP_FAST;
                    if (w.touch_level == TOUCH_MID) next = MODE_SENSED;
                    if (w.touch_level == TOUCH_HIGH) next = MODE_TUNE_DOWN;
                end
                MODE_SENSED: begin
                    motor = MOTOR_HALT;
                    if (w.touch_level == TOUCH_MID || forced) next = MODE_AT_BOARD;
                    if (w.touch_level == TOUCH_HIGH) next = MODE_TUNE_DOWN;
                end
                MODE_TUNE_DOWN: begin
                    motor = MOTOR_DOWN_SLOW;
                    if (w.touch_level == TOUCH_MID) next = MODE_AT_BOARD;
                    if (w.touch_level == TOUCH_LOW) next = MODE_TUNE_UP;
                end
                MODE_TUNE_UP: begin
                    motor = MOTOR_UP_SLOW;
                    if (w.touch_level == TOUCH_MID) next = MODE_AT_BOARD;
                    if (w.touch_level == TOUCH_HIGH) next = MODE_TUNE_DOWN;
                end
                MODE_AT_BOARD: begin
                    motor = MOTOR_HALT;
                    if (dwell_done(forced, settle_thr)) next = MODE_RAISE;
                end
                MODE_RAISE: begin
                    cup_hold = 1'b1;
                    if (dwell_done(forced, raise_thr)) next = MODE_VACUUM;
                end
                MODE_VACUUM: begin
                    vac_hold = 1'b1;
                    if (dwell_done(forced, vacuum_thr)) next = MODE_IN_POS;
                end
                MODE_IN_POS: begin
                    cup_hold = 1'b0;
                    if (forced) next = MODE_DOWN;
                end
                MODE_DOWN: begin
                    motor    = MOTOR_DOWN_FAST;
                    vac_hold = 1'b0;
                    if (forced) next = MODE_STOPPED;
                end
                default: drop_commands();
            endcase
            if (next != mode) dwell = '0;
            mode = next;
            want.mode      = mode;
            want.motor_cmd = motor;
            want.cup_on    = cup_hold;
            want.vacuum_on = vac_hold;
            expected_words.push_back(want);
        endfunction

        task report(string what);
            $display("MISMATCH at %0t: %s", $time, what);
            mismatches++;
        endtask

        task check_word(t_out_word got);
            t_out_word want;
            if (expected_words.size() == 0) begin
                report($sformatf("word %h with nothing outstanding", got));
                return;
            end
            want = expected_words.pop_front();
            if (got.mode !== want.mode)
                report($sformatf("mode %0d, expected %0d", got.mode, want.mode));
            if (got.motor_cmd !== want.motor_cmd)
                report($sformatf("motor %0d, expected %0d", got.motor_cmd, want.motor_cmd));
            if (got.cup_on !== want.cup_on)
                report($sformatf("cup %b, expected %b", got.cup_on, want.cup_on));
            if (got.vacuum_on !== want.vacuum_on)
                report($sformatf("vacuum %b, expected %b", got.vacuum_on, want.vacuum_on));
        endtask
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_wen;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    acs_stream_if #(.t_word(t_in_word))  in_if ();
    acs_stream_if #(.t_word(t_out_word)) out_if ();

    sequencer_mirror mirror;
    bit              steady;
    int              sent;
    int              idle_cycles;

    actuator_cycle_sequencer #(
        .COUNT_BITS(COUNT_BITS)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_wen  (i_cfg_wen),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic t_in_word rest_tick(bit press, logic [1:0] touch);
        t_in_word w;
        w.start_press      = press;
        w.touch_level      = touch;
        w.cup_released     = 1'b1;
        w.cup_lowered      = 1'b1;
        w.vacuum_valve_off = 1'b1;
        w.has_vacuum       = 1'b0;
        w.drive_fault      = 1'b0;
        return w;
    endfunction

    // mostly inputs that move the cycle along, some plain noise
    function automatic t_in_word make_tick();
        t_in_word   w;
        logic [7:0] raw;
        raw = 8'($urandom_range(0, 255));
        w   = raw;
        if ($urandom_range(0, 4) == 0) return w;
        case (mirror.mode)
            MODE_STOPPED: begin
                if ($urandom_range(0, 3) != 0) w = rest_tick(1'b1, TOUCH_LOW);
            end
            MODE_UP, MODE_SENSED, MODE_TUNE_UP, MODE_TUNE_DOWN: begin
                w.touch_level = 2'($urandom_range(0, 2));
                w.start_press = ($urandom_range(0, 7) == 0);
            end
            MODE_AT_BOARD, MODE_RAISE, MODE_VACUUM: begin
                w.start_press = ($urandom_range(0, 5) == 0);
            end
            default: begin
                w.start_press = ($urandom_range(0, 2) == 0);
            end
        endcase
        return w;
    endfunction

    task automatic send_word(t_in_word w);
        int gap;
        if (sent % 30 == 0) steady = ($urandom_range(0, 3) == 0);
        sent++;
        gap = steady ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.word  <= w;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        mirror.note_tick(w);
    endtask

    task automatic run_phase(int n_words);
        for (int k = 0; k < n_words; k++) send_word(make_tick());
        // override phases send up to 100 more words to stop in a settle dwell
        if (mirror.press_force_en) begin
            for (int k = 0; k < 100 && mirror.mode != MODE_AT_BOARD; k++)
                send_word(make_tick());
        end
        in_if.valid <= 1'b0;
        while (mirror.expected_words.size() != 0) @(posedge i_clk);
    endtask

    task automatic load_settings(bit force_en, logic [CFG_DATA_W-1:0] settle,
                                 logic [CFG_DATA_W-1:0] raise,
                                 logic [CFG_DATA_W-1:0] vacuum);
        t_cfg_idx              idx;
        logic [CFG_DATA_W-1:0] val;
        idx = idx.first();
        repeat (idx.num()) begin
            case (idx)
                CFG_PRESS_OVERRIDE: val = {15'($urandom), force_en};
                CFG_SETTLE_TICKS:   val = settle;
                CFG_RAISE_TICKS:    val = raise;
                default:            val = vacuum;
            endcase
            i_cfg_wen  <= 1'b1;
            i_cfg_idx  <= idx;
            i_cfg_data <= val;
            @(posedge i_clk);
            mirror.set_reg(idx, val);
            idx = idx.next();
        end
        i_cfg_wen <= 1'b0;
    endtask

    initial begin
        t_in_word w;
        in_if.valid <= 1'b0;
        in_if.word  <= '0;
        i_cfg_wen   <= 1'b0;
        i_cfg_idx   <= CFG_PRESS_OVERRIDE;
        i_cfg_data  <= '0;
        i_rst_n     <= 1'b0;
        mirror = new();
        steady = 1'b0;
        sent   = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // start refused while any interlock is off its rest condition
        send_word(rest_tick(1'b0, TOUCH_LOW));
        w = rest_tick(1'b1, TOUCH_LOW); w.drive_fault = 1'b1;      send_word(w);
        w = rest_tick(1'b1, TOUCH_LOW); w.has_vacuum = 1'b1;       send_word(w);
        w = rest_tick(1'b1, TOUCH_LOW); w.vacuum_valve_off = 1'b0; send_word(w);
        w = rest_tick(1'b1, TOUCH_LOW); w.cup_lowered = 1'b0;      send_word(w);
        w = rest_tick(1'b1, TOUCH_LOW); w.cup_released = 1'b0;     send_word(w);
        send_word(rest_tick(1'b1, TOUCH_MID));
        send_word(rest_tick(1'b1, TOUCH_NONE));
        send_word(rest_tick(1'b1, TOUCH_LOW));
        // touch sensor walk to the board
        send_word(rest_tick(1'b0, TOUCH_NONE));
        send_word(rest_tick(1'b0, TOUCH_HIGH));
        send_word(rest_tick(1'b0, TOUCH_LOW));
        send_word(rest_tick(1'b0, TOUCH_NONE));
        send_word(rest_tick(1'b0, TOUCH_MID));
        run_phase(40);

        // thresholds drop to zero while the settle dwell is running
        load_settings(1'b1, 16'd0, 16'd0, 16'd0);
        send_word(rest_tick(1'b0, TOUCH_LOW));
        send_word(rest_tick(1'b0, TOUCH_LOW));
        send_word(rest_tick(1'b0, TOUCH_LOW));
        send_word(rest_tick(1'b0, TOUCH_LOW));
        send_word(rest_tick(1'b1, TOUCH_LOW));
        send_word(rest_tick(1'b0, TOUCH_LOW));
        send_word(rest_tick(1'b1, TOUCH_LOW));
        w = rest_tick(1'b1, TOUCH_LOW); w.drive_fault = 1'b1; send_word(w);
        send_word(rest_tick(1'b0, TOUCH_MID));
        send_word(rest_tick(1'b1, TOUCH_HIGH));
        run_phase(55);

        load_settings(1'b1, 16'd3, 16'd1, 16'd5);
        run_phase(65);
        load_settings(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_phase(65);
        load_settings(1'b0, 16'd0, 16'd0, 16'd0);
        run_phase(65);
        load_settings(1'b1, 16'd2, 16'hFFFF, 16'd1);
        run_phase(65);
        load_settings(1'b0, 16'd6, 16'd0, 16'hFFFF);
        run_phase(65);
        load_settings(1'b1, 16'($urandom_range(0, 9)), 16'($urandom_range(0, 9)),
                      16'($urandom_range(0, 9)));
        run_phase(65);

        repeat (5) @(posedge i_clk);
        if (mirror.mismatches == 0 && mirror.expected_words.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin
        int stall;
        int taken;
        out_if.ready <= 1'b0;
        taken = 0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            stall = steady ? 0 : $urandom_range(0, 4);
            // long hold-off so the block backs up into its input
            if (taken == 120 || taken == 380) stall = 40;
            if (stall > 0) begin
                out_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
            do @(posedge i_clk); while (out_if.valid !== 1'b1);
            mirror.check_word(out_if.word);
            taken++;
        end
    end

    initial idle_cycles = 0;
    always @(posedge i_clk) begin
        if ((in_if.valid === 1'b1 && in_if.ready === 1'b1)
            || (out_if.valid === 1'b1 && out_if.ready === 1'b1))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

endmodule

[filelist.f]
+incdir+rtl
rtl/acs_pkg.sv
rtl/acs_stream_if.sv
rtl/acs_cfg.sv
rtl/acs_core.sv
rtl/actuator_cycle_sequencer.sv
rtl/acs_chk.sv
verif/actuator_cycle_sequencer_tb.sv
